@@ design/grammar_symbol_cost_evaluator_defines.svh @@
// Assertion macros for the grammar symbol cost evaluator checker.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef GRAMMAR_SYMBOL_COST_EVALUATOR_DEFINES_SVH
`define GRAMMAR_SYMBOL_COST_EVALUATOR_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define GSCE_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also runs through reset.
`define GSCE_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/gsce_pkg.sv @@
// Shared types and constants of the grammar symbol cost evaluator.
// Depends on nothing; every other file but the defines header imports it.
`default_nettype none

package gsce_pkg;

	localparam int SYMBOLS = 4096;
	localparam int ADDR_W  = $clog2(SYMBOLS);
	localparam int ID_W    = 12;
	localparam int CNT_W   = 16;
	localparam int LEN_W   = 16;
	localparam int COST_W  = 32;
	localparam int KEPT_W  = 13;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [COST_W-1:0] cost_t;

	localparam logic [1:0] SCHEME_SE  = 2'd0;
	localparam logic [1:0] SCHEME_SI  = 2'd1;
	localparam logic [1:0] SCHEME_RSE = 2'd2;

	localparam logic REG_COST_SCHEME = 1'b0;
	localparam logic REG_REF_EXTRA   = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_DROP1,
		S_DROP2,
		S_KEEP1,
		S_KEEP2,
		S_FIN
	} state_t;

	typedef struct packed {
		logic             keep;
		logic [LEN_W-1:0] len;
		cost_t            cost;
	} rec_t;

	typedef struct packed {
		logic  en;
		addr_t laddr;
		addr_t raddr;
	} rec_rd_t;

	typedef struct packed {
		logic  en;
		logic  pos_en;
		addr_t addr;
		rec_t  rec;
		cost_t pos_bits;
	} rec_wr_t;

endpackage

`default_nettype wire

@@ design/gsce_if.sv @@
// Valid/ready channel interfaces: symbol beats in, cost beats out.
// Depends on gsce_pkg.
`default_nettype none

interface gsce_sym_if import gsce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   symbol_id;
	logic              is_base;
	logic [CNT_W-1:0]  use_total;
	logic [CNT_W-1:0]  position_uses;
	logic [CNT_W-1:0]  tree_uses;
	logic [CNT_W-1:0]  run_positions;
	logic [CNT_W-1:0]  run_total;
	logic [ID_W-1:0]   left_id;
	logic [ID_W-1:0]   right_id;
	logic              do_select;
	logic              keep_in;

	modport source (
		output valid, symbol_id, is_base, use_total, position_uses, tree_uses,
			run_positions, run_total, left_id, right_id, do_select, keep_in,
		input  ready
	);
	modport sink (
		input  valid, symbol_id, is_base, use_total, position_uses, tree_uses,
			run_positions, run_total, left_id, right_id, do_select, keep_in,
		output ready
	);
endinterface

interface gsce_cost_if import gsce_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COST_W-1:0]   chosen_cost;
	logic signed [COST_W-1:0] gain;
	logic                keep_out;
	logic [KEPT_W-1:0]   kept_total;

	modport source (
		output valid, chosen_cost, gain, keep_out, kept_total,
		input  ready
	);
	modport sink (
		input  valid, chosen_cost, gain, keep_out, kept_total,
		output ready
	);
endinterface

`default_nettype wire

@@ design/grammar_symbol_cost_evaluator.sv @@
// Grammar symbol cost evaluator, top level.
// The result beat is registered: a symbol passes S_FETCH, S_DROP1, S_DROP2,
// S_KEEP1, S_KEEP2 and S_FIN, and no new symbol is taken until it is done; four
// products go one per cycle through the single shared multiply-add, after the child record reads.
// Reset (arst_n low, async): idle, no result pending, kept count 0, config registers 0.
// Record memories are not cleared; a child record must be written before use.
`default_nettype none

module grammar_symbol_cost_evaluator import gsce_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	gsce_sym_if.sink                sym,
	gsce_cost_if.source             cost,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	// Control state
	state_t            state_q, state_d;
	logic              cost_valid_q;
	logic [KEPT_W-1:0] kept_q;
	logic [1:0]        scheme_q;
	logic [4:0]        rextra_q;

	// Captured symbol beat
	addr_t             id_q;
	logic              base_q, sel_q, keep_in_q;
	logic [CNT_W-1:0]  use_q, pos_q, tree_q, rpos_q, rtot_q;

	// Working values
	logic [LEN_W-1:0]  len_q;
	cost_t             uc_q, pc_q, acc_q, drop_q, keepc_q;

	// Result register
	cost_t             chosen_q, gain_q;
	logic              keep_out_q;
	logic [KEPT_W-1:0] kept_total_q;

	// Record store ports
	rec_rd_t           rd;
	rec_wr_t           wr;
	rec_t              l_rec, r_rec;
	cost_t             l_pos, r_pos;

	// Shared multiply-add
	cost_t             mac_a, mac_b, mac_add, mac_sum;

	logic              sym_acc, cfg_wr, out_load;
	logic              is_rse, is_si;
	cost_t             r32, ref_bits, def_bits, use_m1, gain_c;
	logic              keep_c;
	logic [LEN_W-1:0]  len_c;
	cost_t             uc_c, pc_c;

	gsce_rec_store u_store (
		.clk   (clk),
		.rd    (rd),
		.wr    (wr),
		.l_rec (l_rec),
		.r_rec (r_rec),
		.l_pos (l_pos),
		.r_pos (r_pos)
	);

	gsce_mac u_mac (
		.a      (mac_a),
		.b      (mac_b),
		.addend (mac_add),
		.sum    (mac_sum)
	);

	// APB: writes land in the access phase, reads are combinational
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_COST_SCHEME: prdata = PDATA_W'(scheme_q);
			REG_REF_EXTRA:   prdata = PDATA_W'(rextra_q);
			default:         prdata = '0;
		endcase
	end

	// Scheme code 3 falls back to SE
	assign is_rse   = (scheme_q == SCHEME_RSE);
	assign is_si    = (scheme_q == SCHEME_SI);
	assign r32      = COST_W'(rextra_q);
	assign ref_bits = is_si ? r32 + 32'd2 : r32 + 32'd1;
	assign use_m1   = COST_W'(use_q) - 32'd1;

	assign sym_acc  = sym.valid && sym.ready;
	assign gain_c   = drop_q - keepc_q;

	// Child merge: a kept child counts as one symbol, else its expanded length
	always_comb begin
		if (base_q) begin
			len_c = LEN_W'(1);
			uc_c  = 32'd9;
			pc_c  = 32'd9;
		end else begin
			len_c = (l_rec.keep ? LEN_W'(1) : l_rec.len) +
				(r_rec.keep ? LEN_W'(1) : r_rec.len);
			uc_c  = l_rec.cost + r_rec.cost;
			pc_c  = l_pos + r_pos;
		end
	end

	always_comb begin
		if (base_q) begin
			def_bits = is_si ? 32'd11 : 32'd9;
		end else begin
			def_bits = is_si ? COST_W'(len_q) + 32'd2 : COST_W'(len_q);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (sym_acc) state_d = S_FETCH;
			S_FETCH: state_d = S_DROP1;
			S_DROP1: state_d = S_DROP2;
			S_DROP2: state_d = S_KEEP1;
			S_KEEP1: state_d = S_KEEP2;
			S_KEEP2: state_d = S_FIN;
			S_FIN:   if (!cost_valid_q || cost.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: operand select for the shared unit, load strobes
	always_comb begin
		sym.ready = 1'b0;
		out_load  = 1'b0;
		mac_a     = '0;
		mac_b     = '0;
		mac_add   = '0;
		unique case (state_q)
			S_IDLE: begin
				sym.ready = 1'b1;
			end
			S_DROP1: begin
				// First drop term; base RSE folds all uses into one product
				mac_add = '0;
				if (base_q) begin
					mac_a = is_rse ? COST_W'(pos_q) + COST_W'(tree_q) + COST_W'(rpos_q)
						: COST_W'(use_q);
					mac_b = 32'd9;
				end else if (is_rse) begin
					mac_a = COST_W'(pos_q) + COST_W'(rtot_q);
					mac_b = pc_q;
				end else begin
					mac_a = use_m1;
					mac_b = uc_q;
				end
			end
			S_DROP2: begin
				// Derived RSE: tree*uc - uc taken as (tree-1)*uc
				mac_add = acc_q;
				if (!base_q && is_rse) begin
					mac_a = COST_W'(tree_q) - 32'd1;
					mac_b = uc_q;
				end
			end
			S_KEEP1: begin
				mac_add = def_bits;
				if (is_rse) begin
					mac_a = COST_W'(pos_q);
					mac_b = r32 + 32'd2;
				end else begin
					mac_a = is_si ? use_m1 : COST_W'(use_q);
					mac_b = ref_bits;
				end
			end
			S_KEEP2: begin
				mac_add = acc_q;
				if (is_rse) begin
					mac_a = COST_W'(tree_q) + COST_W'(rpos_q);
					mac_b = r32 + 32'd1;
				end
			end
			S_FIN: begin
				out_load = !cost_valid_q || cost.ready;
			end
			default: begin
				sym.ready = 1'b0;
			end
		endcase
	end

	// Keep decision: positive signed gain when selecting, else the captured keep_in
	assign keep_c = sel_q ? ((gain_c != '0) && !gain_c[COST_W-1]) : keep_in_q;

	// Child reads issue at the accepting edge
	always_comb begin
		rd.en    = sym_acc;
		rd.laddr = addr_t'(sym.left_id);
		rd.raddr = addr_t'(sym.right_id);
	end

	// Write back the symbol record as the result is loaded
	always_comb begin
		wr.en       = out_load;
		wr.pos_en   = is_rse;
		wr.addr     = id_q;
		wr.rec.keep = keep_c;
		wr.rec.len  = len_q;
		wr.rec.cost = keep_c ? ref_bits : uc_q;
		wr.pos_bits = keep_c ? r32 + 32'd2 : pc_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cost_valid_q <= 1'b0;
			kept_q       <= '0;
			scheme_q     <= SCHEME_SE;
			rextra_q     <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				cost_valid_q <= 1'b1;
			end else if (cost.ready) begin
				cost_valid_q <= 1'b0;
			end
			if (out_load && sel_q && keep_c) begin
				kept_q <= kept_q + KEPT_W'(1);
			end
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_COST_SCHEME: scheme_q <= pwdata[1:0];
					REG_REF_EXTRA:   rextra_q <= pwdata[4:0];
					default:         rextra_q <= rextra_q;
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (sym_acc) begin
			id_q      <= addr_t'(sym.symbol_id);
			base_q    <= sym.is_base;
			use_q     <= sym.use_total;
			pos_q     <= sym.position_uses;
			tree_q    <= sym.tree_uses;
			rpos_q    <= sym.run_positions;
			rtot_q    <= sym.run_total;
			sel_q     <= sym.do_select;
			keep_in_q <= sym.keep_in;
		end
		if (state_q == S_FETCH) begin
			len_q <= len_c;
			uc_q  <= uc_c;
			pc_q  <= pc_c;
		end
		if (state_q == S_DROP1 || state_q == S_KEEP1) begin
			acc_q <= mac_sum;
		end
		if (state_q == S_DROP2) begin
			drop_q <= mac_sum;
		end
		if (state_q == S_KEEP2) begin
			keepc_q <= mac_sum;
		end
		if (out_load) begin
			chosen_q     <= keep_c ? keepc_q : drop_q;
			gain_q       <= gain_c;
			keep_out_q   <= keep_c;
			kept_total_q <= (sel_q && keep_c) ? kept_q + KEPT_W'(1) : kept_q;
		end
	end

	assign cost.valid       = cost_valid_q;
	assign cost.chosen_cost = chosen_q;
	assign cost.gain        = gain_q;
	assign cost.keep_out    = keep_out_q;
	assign cost.kept_total  = kept_total_q;

endmodule

`default_nettype wire

@@ design/gsce_rec_store.sv @@
// Symbol record memories: keep/length/cost and position cost.
// Two registered read ports, one write port. Depends on gsce_pkg.
`default_nettype none

module gsce_rec_store import gsce_pkg::*; (
	input  wire logic    clk,
	input  wire rec_rd_t rd,
	input  wire rec_wr_t wr,
	output rec_t         l_rec,
	output rec_t         r_rec,
	output cost_t        l_pos,
	output cost_t        r_pos
);

	rec_t  rec_mem [SYMBOLS];
	cost_t pos_mem [SYMBOLS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			rec_mem[wr.addr] <= wr.rec;
		end
		if (wr.en && wr.pos_en) begin
			pos_mem[wr.addr] <= wr.pos_bits;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			l_rec <= rec_mem[rd.laddr];
			r_rec <= rec_mem[rd.raddr];
			l_pos <= pos_mem[rd.laddr];
			r_pos <= pos_mem[rd.raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/gsce_mac.sv @@
// Shared 32-bit multiply-add: sum = addend + a * b, wrapping.
// Depends on gsce_pkg.
`default_nettype none

module gsce_mac import gsce_pkg::*; (
	input  wire cost_t a,
	input  wire cost_t b,
	input  wire cost_t addend,
	output cost_t      sum
);

	cost_t prod;

	assign prod = a * b;
	assign sum  = addend + prod;

endmodule

`default_nettype wire

@@ design/gsce_checker.sv @@
// Port-level checks on the grammar symbol cost evaluator, bound to the top.
// Depends on gsce_pkg and grammar_symbol_cost_evaluator_defines.svh.
`default_nettype none
`include "grammar_symbol_cost_evaluator_defines.svh"

module gsce_checker import gsce_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              sym_valid,
	input wire logic              sym_ready,
	input wire logic              cost_valid,
	input wire logic              cost_ready,
	input wire logic [COST_W-1:0] cost_chosen,
	input wire logic [COST_W-1:0] cost_gain,
	input wire logic [KEPT_W-1:0] cost_kept
);

	// A stalled result beat holds
	`GSCE_ASSERT_CLK(a_out_hold, cost_valid && !cost_ready |=> cost_valid && $stable(cost_chosen) && $stable(cost_gain) && $stable(cost_kept), "result beat changed while stalled")

	// Busy right after taking a symbol
	`GSCE_ASSERT_CLK(a_busy_after_accept, sym_valid && sym_ready |=> !sym_ready, "ready while evaluating")

	// No result can appear in the cycle after a symbol is taken
	`GSCE_ASSERT_CLK(a_no_early_result, sym_valid && sym_ready |=> !$rose(cost_valid), "result too early")

	// Reset drops any pending result
	`GSCE_ASSERT_ANY(a_reset_clears, !arst_n |-> !cost_valid, "result valid during reset")

endmodule

bind grammar_symbol_cost_evaluator gsce_checker u_gsce_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sym_valid   (sym.valid),
	.sym_ready   (sym.ready),
	.cost_valid  (cost.valid),
	.cost_ready  (cost.ready),
	.cost_chosen (cost.chosen_cost),
	.cost_gain   (cost.gain),
	.cost_kept   (cost.kept_total)
);

`default_nettype wire
